// File: hdl/chs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package chs_pkg;

  // Default geometry of the table
  localparam int BUCKETS_DEF     = 16;
  localparam int CHAIN_DEPTH_DEF = 8;

  // Key and stored word widths; a stored word is {valid, key}
  localparam int KEY_W  = 31;
  localparam int WORD_W = KEY_W + 1;

  // Action codes; search and the unused code both act as a lookup
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

endpackage

`default_nettype wire

// File: hdl/chs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module chs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/chained_hash_set.sv
// Flow: after a request transfer, S_MOD and S_REM take the key modulo BUCKETS (reciprocal
//   multiply, then remainder), S_BASE forms the bucket base address, and each of the k
//   slots scanned (1 to CHAIN_DEPTH) takes S_RD then S_CHK; S_POST posts the result.
// No new request is taken until the result is handed off; S_POST waits while a stalled
//   result keeps the result register full. Each slot costs one read and one check of
//   the table memory. Reset: synchronous; afterwards a clearing pass zeroes all
//   BUCKETS*CHAIN_DEPTH slots of the table, and no request is taken until it ends.
`timescale 1ns / 1ps
`default_nettype none

module chained_hash_set #(
  parameter int BUCKETS     = chs_pkg::BUCKETS_DEF,
  parameter int CHAIN_DEPTH = chs_pkg::CHAIN_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      req_valid,
  output logic                           req_stall,
  input  wire logic [1:0]                action,
  input  wire logic [chs_pkg::KEY_W-1:0] key,
  output logic                           rsp_valid,
  input  wire logic                      rsp_stall,
  output logic                           found,
  output logic      [1:0]                status
);
  import chs_pkg::*;

  localparam int NSLOTS = BUCKETS * CHAIN_DEPTH;
  localparam int AW     = $clog2(NSLOTS);
  localparam int BW     = $clog2(BUCKETS);
  localparam int SW     = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;

  // Reciprocal of the bucket count: exact quotient for every key of KEY_W bits
  localparam int             SHIFT = KEY_W + BW;
  localparam logic [KEY_W:0] RECIP =
    (KEY_W+1)'(((64'd1 << SHIFT) + 64'(BUCKETS - 1)) / 64'(BUCKETS));

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_MOD, S_REM, S_BASE, S_RD, S_CHK, S_POST
  } state_t;

  state_t            state;
  logic [1:0]        act;
  logic [KEY_W-1:0]  key_r;
  logic [BW-1:0]     quo;
  logic [BW-1:0]     rem;
  logic [AW-1:0]     addr;
  logic [SW-1:0]     slot;
  logic              found_r;
  logic [1:0]        status_r;

  logic              ram_we;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] rd_word;
  logic              rd_valid;
  logic [KEY_W-1:0]  rd_key;

  logic [2*KEY_W:0]  prod;
  logic [BW-1:0]     rem_next;
  logic              last_slot;
  logic              match;

  // Table memory: {valid, key} per slot
  chs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NSLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .raddr (addr),
    .rdata (rd_word)
  );

  assign rd_valid = rd_word[KEY_W];
  assign rd_key   = rd_word[KEY_W-1:0];

  // Key modulo bucket count: quotient by reciprocal multiply, remainder from low bits
  assign prod     = (2*KEY_W+1)'(key_r) * (2*KEY_W+1)'(RECIP);
  assign rem_next = key_r[BW-1:0] - BW'(quo * BUCKETS);

  // Slot check
  assign last_slot = (slot == SW'(CHAIN_DEPTH - 1));
  assign match     = rd_valid && (rd_key == key_r);

  assign req_stall = (state != S_IDLE);

  // Table write: clearing pass, insert into a free slot, or remove a match
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    case (state)
      S_CLR: begin
        ram_we = 1'b1;
      end
      S_CHK: begin
        if (act == ACT_INSERT) begin
          if (!rd_valid) begin
            ram_we    = 1'b1;
            ram_wdata = {1'b1, key_r};
          end
        end else if (act == ACT_REMOVE && match) begin
          ram_we = 1'b1;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      addr      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_POST) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          addr <= addr + AW'(1);
          if (addr == AW'(NSLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            act   <= action;
            key_r <= key;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          quo   <= prod[SHIFT +: BW];
          state <= S_REM;
        end
        S_REM: begin
          rem   <= rem_next;
          state <= S_BASE;
        end
        S_BASE: begin
          addr  <= AW'(rem * CHAIN_DEPTH);
          slot  <= '0;
          state <= S_RD;
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (act == ACT_INSERT) begin
            if (!rd_valid) begin
              found_r  <= 1'b0;
              status_r <= ST_OK;
              state    <= S_POST;
            end else if (last_slot) begin
              found_r  <= 1'b0;
              status_r <= ST_FULL;
              state    <= S_POST;
            end else begin
              addr  <= addr + AW'(1);
              slot  <= slot + SW'(1);
              state <= S_RD;
            end
          end else begin
            if (match) begin
              found_r  <= 1'b1;
              status_r <= ST_OK;
              state    <= S_POST;
            end else if (last_slot) begin
              found_r  <= 1'b0;
              status_r <= ST_NOT_FOUND;
              state    <= S_POST;
            end else begin
              addr  <= addr + AW'(1);
              slot  <= slot + SW'(1);
              state <= S_RD;
            end
          end
        end
        S_POST: begin
          // Hand off once the result register is free
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            found     <= found_r;
            status    <= status_r;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A transfer starts the modulo step
  a_start_mod: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == S_MOD))
    else $error("request transfer did not start modulo step");

  // Remainder stays below the bucket count
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_BASE) |-> ({1'b0, rem} < (BW+1)'(BUCKETS)))
    else $error("remainder out of range");

  // Table is written only by the clearing pass or a slot check
  a_write_src: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLR || state == S_CHK))
    else $error("unexpected table write");

  // A match is always reported with status ok
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && found) |-> (status == ST_OK))
    else $error("found with non-ok status");
`endif

endmodule

`default_nettype wire

// File: verif/chs_checker.sv
`timescale 1ns / 1ps

module chs_checker #(
  parameter int BUCKETS     = chs_pkg::BUCKETS_DEF,
  parameter int CHAIN_DEPTH = chs_pkg::CHAIN_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      req_valid,
  input  wire logic                      req_stall,
  input  wire logic [1:0]                action,
  input  wire logic [chs_pkg::KEY_W-1:0] key,
  input  wire logic                      rsp_valid,
  input  wire logic                      rsp_stall,
  input  wire logic                      found,
  input  wire logic [1:0]                status,
  output int                             errors,
  output int                             pending,
  output int                             n_results,
  output int                             n_hit,
  output int                             n_miss,
  output int                             n_full
);
  import chs_pkg::*;

  localparam int NSLOTS     = BUCKETS * CHAIN_DEPTH;
  localparam int PRINT_CAP  = 30;

  typedef struct packed {
    logic       found;
    logic [1:0] status;
  } outcome_t;

  // Shadow copy of the table
  logic [KEY_W-1:0] slot_key  [NSLOTS];
  logic             slot_used [NSLOTS];

  // Outcomes of accepted requests, oldest first
  outcome_t outcome_q[$];

  initial begin
    errors    = 0;
    pending   = 0;
    n_results = 0;
    n_hit     = 0;
    n_miss    = 0;
    n_full    = 0;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_v);
    if (errors < PRINT_CAP)
      $display("%0t: mismatch on %s at result %0d: got %0d, expected %0d",
               $realtime, what, n_results, got, exp_v);
    errors++;
  endtask

  // Apply one request to the shadow table and return its outcome
  function automatic outcome_t apply_request(input logic [1:0] act,
                                             input logic [KEY_W-1:0] k);
    int       base;
    int       hit;
    outcome_t o;
    base     = int'(k % BUCKETS) * CHAIN_DEPTH;
    hit      = -1;
    o.found  = 1'b0;
    o.status = ST_NOT_FOUND;
    if (act == ACT_INSERT) begin
      // lowest free slot of the bucket, else bucket full
      o.status = ST_FULL;
      for (int s = 0; s < CHAIN_DEPTH; s++) begin
        if (!slot_used[base + s]) begin
          slot_key[base + s]  = k;
          slot_used[base + s] = 1'b1;
          o.status = ST_OK;
          break;
        end
      end
    end else begin
      // remove, search and the spare code all look up the lowest match
      for (int s = 0; s < CHAIN_DEPTH; s++) begin
        if (slot_used[base + s] && slot_key[base + s] == k) begin
          hit = s;
          break;
        end
      end
      if (hit >= 0) begin
        o.found  = 1'b1;
        o.status = ST_OK;
        if (act == ACT_REMOVE) slot_used[base + hit] = 1'b0;
      end
    end
    return o;
  endfunction

  task automatic check_result(input logic got_found, input logic [1:0] got_status);
    outcome_t want;
    if (outcome_q.size() == 0) begin
      report_mismatch("result with no request outstanding",
                      32'({got_found, got_status}), 32'd0);
      return;
    end
    want = outcome_q.pop_front();
    if (got_found !== want.found)
      report_mismatch("found", 32'(got_found), 32'(want.found));
    if (got_status !== want.status)
      report_mismatch("status", 32'(got_status), 32'(want.status));
    n_results++;
    if (want.found) n_hit++;
    if (want.status == ST_NOT_FOUND) n_miss++;
    if (want.status == ST_FULL) n_full++;
  endtask

  // Watch both channels on every rising edge
  always @(posedge clk) begin
    if (rst) begin
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      outcome_q.delete();
    end else begin
      if (rsp_valid && !rsp_stall) check_result(found, status);
      if (req_valid && !req_stall) outcome_q.push_back(apply_request(action, key));
    end
    pending = outcome_q.size();
  end

endmodule

// File: verif/tb_chained_hash_set.sv
`timescale 1ns / 1ps

module tb_chained_hash_set;
  import chs_pkg::*;

  localparam int BUCKETS      = BUCKETS_DEF;
  localparam int CHAIN_DEPTH  = CHAIN_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1330;
  localparam int POOL_SIZE    = 24;
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 80;

  localparam logic [1:0]       ACT_SEARCH = 2'd2;
  localparam logic [1:0]       ACT_SPARE  = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MAX    = '1;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_stall;
  logic [1:0]       action    = ACT_INSERT;
  logic [KEY_W-1:0] key       = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  logic             found;
  logic [1:0]       status;

  int errors, pending, n_results, n_hit, n_miss, n_full;
  int sent_cnt    = 0;
  int idle_cycles = 0;

  // Receiver pattern state
  int rx_mode    = 0;
  int rx_left    = 0;
  int hold_left  = 0;
  bit hold1_done = 1'b0;
  bit hold2_done = 1'b0;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  chained_hash_set #(
    .BUCKETS     (BUCKETS),
    .CHAIN_DEPTH (CHAIN_DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .action    (action),
    .key       (key),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .found     (found),
    .status    (status)
  );

  chs_checker #(
    .BUCKETS     (BUCKETS),
    .CHAIN_DEPTH (CHAIN_DEPTH)
  ) u_check (.*);

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Receiver: stall modes that change now and then, plus two long hold-offs
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(30, 300);
    end else begin
      rx_left--;
    end
    if (!hold1_done && sent_cnt >= 500) begin
      hold1_done = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (!hold2_done && sent_cnt >= 1100) begin
      hold2_done = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      case (rx_mode)
        0:       rsp_stall <= 1'b0;
        1:       rsp_stall <= ($urandom_range(0, 2) == 0);
        default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
      $display("[chained_hash_set] ERROR");
      $finish;
    end
  end

  // Offer one request and hold it until the transfer
  task automatic send_request(input logic [1:0] act, input logic [KEY_W-1:0] k);
    @(negedge clk);
    req_valid <= 1'b1;
    action    <= act;
    key       <= k;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent_cnt++;
  endtask

  task automatic pause_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
  endtask

  initial begin
    int               burst_left;
    int               roll;
    int unsigned      r;
    int               hot [3];
    logic [1:0]       act;
    logic [KEY_W-1:0] k;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, both key extremes, duplicates, every action code
    send_request(ACT_SEARCH, '0);
    send_request(ACT_REMOVE, '0);
    send_request(ACT_INSERT, '0);
    send_request(ACT_INSERT, KEY_MAX);
    send_request(ACT_SEARCH, KEY_MAX);
    send_request(ACT_SPARE,  KEY_MAX);
    send_request(ACT_INSERT, KEY_MAX);
    send_request(ACT_REMOVE, KEY_MAX);
    send_request(ACT_SEARCH, KEY_MAX);
    send_request(ACT_REMOVE, KEY_MAX);
    send_request(ACT_REMOVE, KEY_MAX);
    send_request(ACT_SEARCH, '0);

    // Fill one bucket, overflow it, free a middle slot and refill it
    for (int i = 0; i < CHAIN_DEPTH; i++)
      send_request(ACT_INSERT, (i == 1) ? KEY_W'((1 << 30) + 5) : KEY_W'(5 + i * BUCKETS));
    send_request(ACT_INSERT, KEY_W'(5 + CHAIN_DEPTH * BUCKETS));
    send_request(ACT_REMOVE, KEY_W'(5 + 3 * BUCKETS));
    send_request(ACT_INSERT, KEY_W'(5 + CHAIN_DEPTH * BUCKETS));
    send_request(ACT_SEARCH, KEY_W'(5 + CHAIN_DEPTH * BUCKETS));
    send_request(ACT_SPARE,  KEY_W'(5 + (CHAIN_DEPTH + 1) * BUCKETS));

    // Random: mostly keys from a small pool crowded into a few buckets,
    // alternating insert-heavy and remove-heavy stretches
    burst_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 200 == 0) begin
        foreach (hot[j]) hot[j] = $urandom_range(0, BUCKETS - 1);
        foreach (key_pool[j]) begin
          r = $urandom_range(0, (32'h7FFF_FFFF - BUCKETS + 1) / BUCKETS);
          key_pool[j] = KEY_W'(r * BUCKETS + hot[j % 3]);
        end
      end
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        k    = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        roll = $urandom_range(0, 99);
        if ((i / 100) % 2 == 0)
          act = (roll < 50) ? ACT_INSERT : (roll < 70) ? ACT_REMOVE :
                (roll < 95) ? ACT_SEARCH : ACT_SPARE;
        else
          act = (roll < 20) ? ACT_INSERT : (roll < 70) ? ACT_REMOVE :
                (roll < 95) ? ACT_SEARCH : ACT_SPARE;
      end else begin
        // stray keys anywhere in the key range, rarely stored
        k    = KEY_W'($urandom());
        roll = $urandom_range(0, 99);
        act  = (roll < 10) ? ACT_INSERT : (roll < 40) ? ACT_REMOVE :
               (roll < 85) ? ACT_SEARCH : ACT_SPARE;
      end
      // bursts with gaps, except for some back-to-back stretches
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        if ((i / 150) % 4 != 3) pause_sender($urandom_range(1, 12));
      end
      burst_left--;
      send_request(act, k);
    end

    @(negedge clk);
    req_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d requests through crowded buckets and two long response hold-offs.",
             sent_cnt);
    $display("Checked %0d results: %0d hits, %0d misses, %0d bucket-full rejections.",
             n_results, n_hit, n_miss, n_full);
    if (errors == 0 && pending == 0) begin
      $display("[chained_hash_set] OK");
    end else begin
      $display("[chained_hash_set] ERROR");
    end
    $finish;
  end

endmodule
